/* rtl/dead_reckoning_path_recorder_macros.svh */
// Assertion macros shared by the path recorder modules.
`ifndef DEAD_RECKONING_PATH_RECORDER_MACROS_SVH
`define DEAD_RECKONING_PATH_RECORDER_MACROS_SVH

// Same-cycle implication, checked on clock outside reset.
`define DRPR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock outside reset.
`define DRPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/drpr_pkg.sv */
// Types, constants and the sine table shared by the path recorder.
package drpr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_TRIG,
      ST_MUL,
      ST_ACC,
      ST_WHOLE,
      ST_STORE,
      ST_READ,
      ST_FETCH,
      ST_SPAN,
      ST_SCALE,
      ST_DONE
   } state_type;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_W = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_H = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  VIEW_W_RESET = 10'd320;
   localparam logic [CSR_DATA_W-1:0]  VIEW_H_RESET = 10'd240;

   localparam int INDEX_W      = 6;
   localparam int FULL_TURN    = 360;
   localparam int HALF_TURN    = 180;
   localparam int QUARTER_TURN = 90;
   localparam int SLOT_MARGIN  = 2;
   localparam int SHIFT_CAP    = 16;
   localparam int DELTA_LIMIT  = 127;
   localparam int EXACT_MIN    = -32768 * 256;
   localparam int EXACT_MAX    = 32767 * 256 + 255;
   localparam int ROUND_HALF   = 64;

   typedef struct packed {
      logic       accept;
      logic [1:0] op;
      logic       head;
      logic       trig;
      logic       mul;
      logic       acc;
      logic       whole;
      logic       axis;    // 0: x (cosine), 1: y (sine)
      logic       store;
      logic       read;
      logic       fetch;
      logic       span;
      logic       scale;
   } ctrl_type;

   // Quarter-wave sine in unsigned Q0.15, one entry per degree, 1.0 held as 32767.
   localparam logic [14:0] SINE_Q15 [0:90] = '{
      15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
      15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
      15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
      15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
      15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
      15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
      15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
      15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
      15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
      15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
      15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
      15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
      15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
   };

   // Sine of a whole-degree angle (0..359), folded onto the quarter table.
   function automatic logic signed [16:0] trig_of(input logic [8:0] angle);
      logic [8:0]         folded;
      logic               negate;
      logic signed [16:0] mag;
      if (angle <= 9'(QUARTER_TURN)) begin
         folded = angle;
         negate = 1'b0;
      end else if (angle <= 9'(HALF_TURN)) begin
         folded = 9'(HALF_TURN) - angle;
         negate = 1'b0;
      end else if (angle <= 9'(HALF_TURN + QUARTER_TURN)) begin
         folded = angle - 9'(HALF_TURN);
         negate = 1'b1;
      end else begin
         folded = 9'(FULL_TURN) - angle;
         negate = 1'b1;
      end
      mag = $signed({2'b00, SINE_Q15[folded[6:0]]});
      return negate ? -mag : mag;
   endfunction

endpackage

/* rtl/drpr_mem.sv */
// Delta pair store: one write port, one registered read port.
module drpr_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] pair_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pair_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/drpr_ctrl.sv */
// Sequencer that steps the shared datapath through one transaction.
`include "dead_reckoning_path_recorder_macros.svh"

module drpr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_type,
   input  logic               scale_done,
   output logic               busy,
   output logic               rsp_valid,
   output drpr_pkg::ctrl_type ctrl
);

   drpr_pkg::state_type state_ff, state_in;
   logic                axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drpr_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drpr_pkg::ST_IDLE: begin
            if (start) begin
               case (req_type)
                  drpr_pkg::REQ_ADD:  state_in = drpr_pkg::ST_HEAD;
                  drpr_pkg::REQ_READ: state_in = drpr_pkg::ST_READ;
                  default:            state_in = drpr_pkg::ST_SPAN;
               endcase
            end
         end
         drpr_pkg::ST_HEAD:  state_in = drpr_pkg::ST_TRIG;
         drpr_pkg::ST_TRIG:  state_in = drpr_pkg::ST_MUL;
         drpr_pkg::ST_MUL:   state_in = drpr_pkg::ST_ACC;
         drpr_pkg::ST_ACC:   state_in = drpr_pkg::ST_WHOLE;
         drpr_pkg::ST_WHOLE: state_in = axis_ff ? drpr_pkg::ST_STORE : drpr_pkg::ST_TRIG;
         drpr_pkg::ST_STORE: state_in = drpr_pkg::ST_SPAN;
         drpr_pkg::ST_READ:  state_in = drpr_pkg::ST_FETCH;
         drpr_pkg::ST_FETCH: state_in = drpr_pkg::ST_SPAN;
         drpr_pkg::ST_SPAN:  state_in = drpr_pkg::ST_SCALE;
         drpr_pkg::ST_SCALE: state_in = scale_done ? drpr_pkg::ST_DONE : drpr_pkg::ST_SCALE;
         drpr_pkg::ST_DONE:  state_in = drpr_pkg::ST_IDLE;
         default:            state_in = drpr_pkg::ST_IDLE;
      endcase
   end

   // x axis first, then y
   always_comb begin
      axis_in = axis_ff;
      case (state_ff)
         drpr_pkg::ST_HEAD:  axis_in = 1'b0;
         drpr_pkg::ST_WHOLE: axis_in = 1'b1;
         default:            axis_in = axis_ff;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      ctrl.op   = req_type;
      ctrl.axis = axis_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         drpr_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ctrl.accept = start;
         end
         drpr_pkg::ST_HEAD:  ctrl.head  = 1'b1;
         drpr_pkg::ST_TRIG:  ctrl.trig  = 1'b1;
         drpr_pkg::ST_MUL:   ctrl.mul   = 1'b1;
         drpr_pkg::ST_ACC:   ctrl.acc   = 1'b1;
         drpr_pkg::ST_WHOLE: ctrl.whole = 1'b1;
         drpr_pkg::ST_STORE: ctrl.store = 1'b1;
         drpr_pkg::ST_READ:  ctrl.read  = 1'b1;
         drpr_pkg::ST_FETCH: ctrl.fetch = 1'b1;
         drpr_pkg::ST_SPAN:  ctrl.span  = 1'b1;
         drpr_pkg::ST_SCALE: ctrl.scale = 1'b1;
         drpr_pkg::ST_DONE:  rsp_valid  = 1'b1;
         default:            busy       = 1'b1;
      endcase
   end

   `DRPR_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted transaction did not start")
   `DRPR_ASSERT_NEXT(a_done_returns_idle, rsp_valid, !busy, "block not idle after result")
   `DRPR_ASSERT_IMP(a_store_after_y, state_ff == drpr_pkg::ST_STORE, axis_ff, "store before y axis")

endmodule

/* rtl/drpr_datapath.sv */
// Heading, shared multiplier, accumulator, bounding box and scale search.
`include "dead_reckoning_path_recorder_macros.svh"

module drpr_datapath #(
   parameter int PATH_DEPTH = 64,
   localparam int ADDR_W = $clog2(PATH_DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drpr_pkg::ctrl_type                    ctrl,
   input  logic signed [9:0]                     req_turn_degrees,
   input  logic signed [7:0]                     req_length_cm,
   input  logic [drpr_pkg::INDEX_W-1:0]          req_read_index,
   input  logic                                  csr_we,
   input  logic [drpr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [drpr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [ADDR_W-1:0]                     mem_wr_addr,
   output logic [15:0]                           mem_wr_data,
   output logic [ADDR_W-1:0]                     mem_rd_addr,
   input  logic [15:0]                           mem_rd_data,
   output logic                                  scale_done,
   output logic signed [7:0]                     rsp_delta_x,
   output logic signed [7:0]                     rsp_delta_y,
   output logic signed [15:0]                    rsp_pos_x,
   output logic signed [15:0]                    rsp_pos_y,
   output logic signed [15:0]                    rsp_min_x,
   output logic [14:0]                           rsp_max_x,
   output logic signed [15:0]                    rsp_min_y,
   output logic [14:0]                           rsp_max_y,
   output logic [4:0]                            rsp_scale_shift,
   output logic [drpr_pkg::INDEX_W-1:0]          rsp_segment_count
);

   localparam int CMP_W = (ADDR_W > drpr_pkg::INDEX_W) ? ADDR_W : drpr_pkg::INDEX_W;
   localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(PATH_DEPTH - drpr_pkg::SLOT_MARGIN);
   localparam logic signed [11:0] TURN_ONE = 12'(drpr_pkg::FULL_TURN);
   localparam logic signed [11:0] TURN_TWO = 12'(2 * drpr_pkg::FULL_TURN);
   localparam logic [8:0] COS_WRAP = 9'(drpr_pkg::FULL_TURN - drpr_pkg::QUARTER_TURN);
   localparam logic [8:0] COS_ADD  = 9'(drpr_pkg::QUARTER_TURN);
   localparam logic signed [25:0] EXACT_LO = 26'(drpr_pkg::EXACT_MIN);
   localparam logic signed [25:0] EXACT_HI = 26'(drpr_pkg::EXACT_MAX);
   localparam logic signed [16:0] DELTA_HI = 17'(drpr_pkg::DELTA_LIMIT);
   localparam logic signed [16:0] DELTA_LO = -17'(drpr_pkg::DELTA_LIMIT);
   localparam logic [4:0] SHIFT_MAX = 5'(drpr_pkg::SHIFT_CAP);

   // configuration
   logic [9:0] width_ff, width_in, height_ff, height_in;
   // path state
   logic [8:0]               heading_ff, heading_in;
   logic signed [24:0]       exact_x_ff, exact_x_in, exact_y_ff, exact_y_in;
   logic signed [15:0]       whole_x_ff, whole_x_in, whole_y_ff, whole_y_in;
   logic signed [15:0]       low_x_ff, low_x_in, low_y_ff, low_y_in;
   logic [14:0]              high_x_ff, high_x_in, high_y_ff, high_y_in;
   logic [ADDR_W-1:0]        slot_ff, slot_in;
   logic signed [7:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [4:0]               shift_ff, shift_in;
   // working registers
   logic signed [9:0]        turn_ff, turn_in;
   logic signed [7:0]        len_ff, len_in;
   logic [drpr_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic signed [16:0]       trig_ff, trig_in;
   logic signed [24:0]       prod_ff, prod_in;
   logic                     hit_ff, hit_in;
   logic [15:0]              xd_ff, xd_in, yd_ff, yd_in;

   logic signed [11:0]       head_sum, head_wrap;
   logic [8:0]               angle;
   logic signed [24:0]       mul_full;
   logic signed [24:0]       step;
   logic signed [24:0]       exact_sel;
   logic signed [25:0]       acc_sum;
   logic signed [24:0]       exact_sat;
   logic signed [24:0]       exact_bias;
   logic signed [24:0]       whole_wide;
   logic signed [15:0]       whole_new;
   logic signed [15:0]       whole_sel;
   logic signed [16:0]       delta_wide;
   logic signed [7:0]        delta_sat;
   logic [CMP_W-1:0]         idx_cmp, slot_cmp;
   logic [16:0]              span_x, span_y;
   logic                     fits;

   // heading wrap into 0..359
   always_comb begin
      head_sum = $signed({3'b000, heading_ff}) + $signed({{2{turn_ff[9]}}, turn_ff});
      if (head_sum < -TURN_ONE) begin
         head_wrap = head_sum + TURN_TWO;
      end else if (head_sum < 12'sd0) begin
         head_wrap = head_sum + TURN_ONE;
      end else if (head_sum >= TURN_TWO) begin
         head_wrap = head_sum - TURN_TWO;
      end else if (head_sum >= TURN_ONE) begin
         head_wrap = head_sum - TURN_ONE;
      end else begin
         head_wrap = head_sum;
      end
   end

   // cos(h) is sin(h + 90)
   always_comb begin
      if (ctrl.axis) begin
         angle = heading_ff;
      end else if (heading_ff >= COS_WRAP) begin
         angle = heading_ff - COS_WRAP;
      end else begin
         angle = heading_ff + COS_ADD;
      end
   end

   assign mul_full  = 25'(trig_ff) * 25'(len_ff);
   assign step      = prod_ff >>> 7;
   assign exact_sel = ctrl.axis ? exact_y_ff : exact_x_ff;
   assign acc_sum   = $signed({exact_sel[24], exact_sel}) + $signed({step[24], step});

   always_comb begin
      if (acc_sum < EXACT_LO) begin
         exact_sat = EXACT_LO[24:0];
      end else if (acc_sum > EXACT_HI) begin
         exact_sat = EXACT_HI[24:0];
      end else begin
         exact_sat = acc_sum[24:0];
      end
   end

   // truncate toward zero
   assign exact_bias = exact_sel + 25'sd255;
   assign whole_wide = exact_sel[24] ? (exact_bias >>> 8) : (exact_sel >>> 8);
   assign whole_new  = whole_wide[15:0];
   assign whole_sel  = ctrl.axis ? whole_y_ff : whole_x_ff;
   assign delta_wide = $signed({whole_new[15], whole_new}) - $signed({whole_sel[15], whole_sel});

   always_comb begin
      if (delta_wide > DELTA_HI) begin
         delta_sat = DELTA_HI[7:0];
      end else if (delta_wide < DELTA_LO) begin
         delta_sat = DELTA_LO[7:0];
      end else begin
         delta_sat = delta_wide[7:0];
      end
   end

   assign idx_cmp  = CMP_W'(idx_ff);
   assign slot_cmp = CMP_W'(slot_ff);
   assign span_x   = {2'b00, high_x_ff} - {low_x_ff[15], low_x_ff};
   assign span_y   = {2'b00, high_y_ff} - {low_y_ff[15], low_y_ff};
   assign fits       = (xd_ff <= {6'b000000, width_ff}) && (yd_ff < {6'b000000, height_ff});
   assign scale_done = fits || (shift_ff == SHIFT_MAX);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      heading_in = heading_ff;
      exact_x_in = exact_x_ff;
      exact_y_in = exact_y_ff;
      whole_x_in = whole_x_ff;
      whole_y_in = whole_y_ff;
      low_x_in   = low_x_ff;
      low_y_in   = low_y_ff;
      high_x_in  = high_x_ff;
      high_y_in  = high_y_ff;
      slot_in    = slot_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      shift_in   = shift_ff;

      if (csr_we) begin
         case (csr_index)
            drpr_pkg::CSR_VIEW_W: width_in  = csr_wdata;
            drpr_pkg::CSR_VIEW_H: height_in = csr_wdata;
            default:              width_in  = width_ff;
         endcase
      end

      if (ctrl.accept) begin
         dx_in = '0;
         dy_in = '0;
         if (ctrl.op == drpr_pkg::REQ_CLEAR) begin
            heading_in = '0;
            exact_x_in = '0;
            exact_y_in = '0;
            whole_x_in = '0;
            whole_y_in = '0;
            low_x_in   = '0;
            low_y_in   = '0;
            high_x_in  = '0;
            high_y_in  = '0;
            slot_in    = '0;
         end
      end

      if (ctrl.head) begin
         heading_in = head_wrap[8:0];
      end

      if (ctrl.acc) begin
         if (ctrl.axis) begin
            exact_y_in = exact_sat;
         end else begin
            exact_x_in = exact_sat;
         end
      end

      if (ctrl.whole) begin
         if (ctrl.axis) begin
            whole_y_in = whole_new;
            dy_in      = delta_sat;
            if (whole_new > $signed({1'b0, high_y_ff})) high_y_in = whole_new[14:0];
            if (whole_new < low_y_ff)                   low_y_in  = whole_new;
         end else begin
            whole_x_in = whole_new;
            dx_in      = delta_sat;
            if (whole_new > $signed({1'b0, high_x_ff})) high_x_in = whole_new[14:0];
            if (whole_new < low_x_ff)                   low_x_in  = whole_new;
         end
      end

      // hold the last slot once the store is full
      if (ctrl.store && (slot_ff < SLOT_LAST)) begin
         slot_in = slot_ff + ADDR_W'(1);
      end

      if (ctrl.fetch) begin
         dx_in = hit_ff ? $signed(mem_rd_data[15:8]) : 8'sd0;
         dy_in = hit_ff ? $signed(mem_rd_data[7:0])  : 8'sd0;
      end

      if (ctrl.span) begin
         shift_in = '0;
      end else if (ctrl.scale && !scale_done) begin
         shift_in = shift_ff + 5'd1;
      end
   end

   always_comb begin
      turn_in = ctrl.accept ? req_turn_degrees : turn_ff;
      len_in  = ctrl.accept ? req_length_cm    : len_ff;
      idx_in  = ctrl.accept ? req_read_index   : idx_ff;
      trig_in = ctrl.trig ? drpr_pkg::trig_of(angle) : trig_ff;
      prod_in = ctrl.mul ? (mul_full + 25'(drpr_pkg::ROUND_HALF)) : prod_ff;
      hit_in  = ctrl.read ? (idx_cmp < slot_cmp) : hit_ff;
      xd_in   = xd_ff;
      yd_in   = yd_ff;
      if (ctrl.span) begin
         xd_in = span_x[15:0];
         yd_in = span_y[15:0];
      end else if (ctrl.scale && !scale_done) begin
         xd_in = xd_ff >> 1;
         yd_in = yd_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= drpr_pkg::VIEW_W_RESET;
         height_ff  <= drpr_pkg::VIEW_H_RESET;
         heading_ff <= '0;
         exact_x_ff <= '0;
         exact_y_ff <= '0;
         whole_x_ff <= '0;
         whole_y_ff <= '0;
         low_x_ff   <= '0;
         low_y_ff   <= '0;
         high_x_ff  <= '0;
         high_y_ff  <= '0;
         slot_ff    <= '0;
         dx_ff      <= '0;
         dy_ff      <= '0;
         shift_ff   <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         heading_ff <= heading_in;
         exact_x_ff <= exact_x_in;
         exact_y_ff <= exact_y_in;
         whole_x_ff <= whole_x_in;
         whole_y_ff <= whole_y_in;
         low_x_ff   <= low_x_in;
         low_y_ff   <= low_y_in;
         high_x_ff  <= high_x_in;
         high_y_ff  <= high_y_in;
         slot_ff    <= slot_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         shift_ff   <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      turn_ff <= turn_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      trig_ff <= trig_in;
      prod_ff <= prod_in;
      hit_ff  <= hit_in;
      xd_ff   <= xd_in;
      yd_ff   <= yd_in;
   end

   assign mem_wr_addr = slot_ff;
   assign mem_wr_data = {dx_ff, dy_ff};
   assign mem_rd_addr = idx_cmp[ADDR_W-1:0];

   assign rsp_delta_x       = dx_ff;
   assign rsp_delta_y       = dy_ff;
   assign rsp_pos_x         = whole_x_ff;
   assign rsp_pos_y         = whole_y_ff;
   assign rsp_min_x         = low_x_ff;
   assign rsp_max_x         = high_x_ff;
   assign rsp_min_y         = low_y_ff;
   assign rsp_max_y         = high_y_ff;
   assign rsp_scale_shift   = shift_ff;
   assign rsp_segment_count = slot_cmp[drpr_pkg::INDEX_W-1:0];

   `DRPR_ASSERT_IMP(a_heading_range, 1'b1, heading_ff < 9'(drpr_pkg::FULL_TURN), "heading out of range")
   `DRPR_ASSERT_IMP(a_slot_range, 1'b1, slot_ff <= SLOT_LAST, "write slot past last slot")
   `DRPR_ASSERT_IMP(a_box_holds_x, !ctrl.whole, (whole_x_ff >= low_x_ff) && (whole_x_ff <= $signed({1'b0, high_x_ff})), "x position outside box")

endmodule

/* rtl/dead_reckoning_path_recorder.sv */
// Top level of the dead-reckoning path recorder.
//
// Usage: drive req_type and the req_ payload with start high; the transaction
// is taken at a clock edge where start is high and busy is low. Add segment
// turns the heading, advances the position by cos/sin of the heading times
// the length, stores the delta pair and widens the bounding box. Read returns
// a stored pair (zeros beyond the count); clear resets the path.
// Every transaction gives one result on the rsp_ ports, marked by rsp_valid for
// exactly one cycle; the receiver cannot stall it.
// The reported scale_shift lies in 0..16. busy stays high until rsp_valid
// has been shown, so no new transaction is taken before the last result.
// A single multiplier serves both axes in turn, and the scale search shifts
// the box one bit per cycle.
// The csr_ port writes the x span limit (index 0) or the y span limit
// (index 1), one per write; write only while idle.
// Synchronous reset returns the path to the origin, heading zero, no stored
// segments and span limits 320 and 240; the pair store is not cleared.
module dead_reckoning_path_recorder #(
   parameter int PATH_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic signed [9:0]                req_turn_degrees,
   input  logic signed [7:0]                req_length_cm,
   input  logic [drpr_pkg::INDEX_W-1:0]     req_read_index,
   input  logic                             csr_we,
   input  logic [drpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [drpr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             rsp_valid,
   output logic signed [7:0]                rsp_delta_x,
   output logic signed [7:0]                rsp_delta_y,
   output logic signed [15:0]               rsp_pos_x,
   output logic signed [15:0]               rsp_pos_y,
   output logic signed [15:0]               rsp_min_x,
   output logic [14:0]                      rsp_max_x,
   output logic signed [15:0]               rsp_min_y,
   output logic [14:0]                      rsp_max_y,
   output logic [4:0]                       rsp_scale_shift,
   output logic [drpr_pkg::INDEX_W-1:0]     rsp_segment_count
);

   localparam int ADDR_W = $clog2(PATH_DEPTH);

   drpr_pkg::ctrl_type ctrl;
   logic               scale_done;
   logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
   logic [15:0]        mem_wr_data, mem_rd_data;

   drpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .scale_done (scale_done),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .ctrl       (ctrl)
   );

   drpr_datapath #(
      .PATH_DEPTH (PATH_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_turn_degrees  (req_turn_degrees),
      .req_length_cm     (req_length_cm),
      .req_read_index    (req_read_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .scale_done        (scale_done),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_min_x         (rsp_min_x),
      .rsp_max_x         (rsp_max_x),
      .rsp_min_y         (rsp_min_y),
      .rsp_max_y         (rsp_max_y),
      .rsp_scale_shift   (rsp_scale_shift),
      .rsp_segment_count (rsp_segment_count)
   );

   drpr_mem #(
      .DEPTH  (PATH_DEPTH),
      .DATA_W (16)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ctrl.store),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (ctrl.read),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
